// File: rtl/qte_pkg.sv
// package: types, constants and tables shared by the quaternion to euler angle core
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CW            = 36;
  localparam int VW            = 34;
  localparam int SQ_STEPS      = 29;
  localparam int CORD_LAT      = CORDIC_STAGES + 1;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               gimbal_lock;
  } euler_t;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] yz;
    logic signed [31:0] wy;
    logic signed [31:0] xz;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] wz;
  } prod_t;

  typedef struct packed {
    logic               lock;
    logic signed [15:0] sp;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] roll_x;
  } side_t;

  typedef struct packed {
    logic               lock;
    logic signed [15:0] sp;
  } tag_t;

endpackage

// File: rtl/quaternion_to_euler_angles_core.sv
// top level: quaternion to euler angles pipeline with output register
//
// Takes one Q1.14 quaternion per cycle while the output is not stalled and
// returns pitch, yaw and roll as binary angles (32768 = pi) plus a gimbal
// lock flag. Each word passes the product and prep stages, the
// one-bit-per-stage square root for the pitch cosine, the unrolled cordic
// and the output register. The whole pipeline holds while a finished word
// waits at the output. The gimbal threshold register may be written only
// while the pipeline is empty.
module quaternion_to_euler_angles_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [14:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qte_pkg::quat_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qte_pkg::euler_t out_data_o
);

  localparam int L = qte_pkg::CORD_LAT;

  logic            en;
  logic [14:0]     thr_q;
  logic            v1, v3, vs, vp, vy, vr;
  qte_pkg::prod_t  prod;
  logic [28:0]     rad, root;
  qte_pkg::side_t  side3, sides;
  logic [15:0]     ang_p, ang_y, ang_r;
  qte_pkg::tag_t   tag_q [L];
  logic            ov_q;
  qte_pkg::euler_t out_d, out_q;
  logic signed [15:0] ap;

  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd16382;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  qte_mult u_mult (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .q_i(in_data_i),
    .valid_o(v1), .p_o(prod)
  );

  qte_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .thr_i(thr_q), .valid_i(v1), .p_i(prod),
    .valid_o(v3), .rad_o(rad), .side_o(side3)
  );

  qte_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3), .rad_i(rad), .side_i(side3),
    .valid_o(vs), .root_o(root), .side_o(sides)
  );

  qte_cordic u_cord_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs),
    .x_i({7'd0, root}),
    .y_i({{6{sides.sp[15]}}, sides.sp, 14'd0}),
    .valid_o(vp), .angle_o(ang_p)
  );

  qte_cordic u_cord_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs),
    .x_i({{2{sides.yaw_x[33]}}, sides.yaw_x}),
    .y_i({{2{sides.yaw_y[33]}}, sides.yaw_y}),
    .valid_o(vy), .angle_o(ang_y)
  );

  qte_cordic u_cord_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs),
    .x_i({{2{sides.roll_x[33]}}, sides.roll_x}),
    .y_i({{2{sides.roll_y[33]}}, sides.roll_y}),
    .valid_o(vr), .angle_o(ang_r)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0].lock <= sides.lock;
      tag_q[0].sp   <= sides.sp;
      for (int i = 1; i < L; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_comb begin
    ap = $signed(ang_p);
    if (tag_q[L-1].lock) begin
      out_d.pitch_angle = tag_q[L-1].sp;
    end else if (ap > 16'sd16384) begin
      out_d.pitch_angle = 16'sd16384;
    end else if (ap < -16'sd16384) begin
      out_d.pitch_angle = -16'sd16384;
    end else begin
      out_d.pitch_angle = ap;
    end
    out_d.yaw_angle   = $signed(ang_y);
    out_d.roll_angle  = tag_q[L-1].lock ? 16'sd0 : $signed(ang_r);
    out_d.gimbal_lock = tag_q[L-1].lock;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vp && vy && vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/qte_mult.sv
// first stage: the component products of the quaternion that the angles need
module qte_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qte_pkg::quat_t q_i,
  output logic           valid_o,
  output qte_pkg::prod_t p_o
);

  qte_pkg::prod_t p_d, p_q;
  logic           v_q;

  always_comb begin
    p_d.wx = q_i.qw * q_i.qx;
    p_d.yz = q_i.qy * q_i.qz;
    p_d.wy = q_i.qw * q_i.qy;
    p_d.xz = q_i.qx * q_i.qz;
    p_d.xx = q_i.qx * q_i.qx;
    p_d.yy = q_i.qy * q_i.qy;
    p_d.zz = q_i.qz * q_i.qz;
    p_d.xy = q_i.qx * q_i.qy;
    p_d.wz = q_i.qw * q_i.qz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign valid_o = v_q;
  assign p_o     = p_q;

endmodule

// File: rtl/qte_prep.sv
// stages two and three: sin(pitch), gimbal test, cordic vectors and sqrt radicand
module qte_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [14:0]    thr_i,
  input  logic           valid_i,
  input  qte_pkg::prod_t p_i,
  output logic           valid_o,
  output logic [28:0]    rad_o,
  output qte_pkg::side_t side_o
);

  localparam logic signed [33:0] ONE_Q28  = 34'sh0_1000_0000;
  localparam logic signed [33:0] HALF_Q28 = 34'sh0_0800_0000;

  logic signed [32:0]          diff;
  logic signed [33:0]          s28, s28_sat;
  logic [33:0]                 u;
  logic signed [15:0]          sp_d, sp_q;
  logic signed [qte_pkg::VW-1:0] yl_y_d, yl_x_d, yn_y_d, yn_x_d, r_y_d, r_x_d;
  logic signed [qte_pkg::VW-1:0] yl_y_q, yl_x_q, yn_y_q, yn_x_q, r_y_q, r_x_q;
  logic                        v2_q, v3_q;
  logic [15:0]                 mag;
  logic signed [31:0]          sq;
  logic [28:0]                 rad_d, rad_q;
  qte_pkg::side_t              side_d, side_q;

  // stage two
  always_comb begin
    diff = 33'(p_i.wx) - 33'(p_i.yz);
    s28  = {diff, 1'b0};
    if (s28 > ONE_Q28) begin
      s28_sat = ONE_Q28;
    end else if (s28 < -ONE_Q28) begin
      s28_sat = -ONE_Q28;
    end else begin
      s28_sat = s28;
    end
    u      = 34'(s28_sat + ONE_Q28 + 34'sd8192);
    sp_d   = $signed(u[29:14] - 16'd16384);
    yl_y_d = 34'(p_i.wy) - 34'(p_i.xz);
    yl_x_d = HALF_Q28 - 34'(p_i.yy) - 34'(p_i.zz);
    yn_y_d = 34'(p_i.xz) + 34'(p_i.wy);
    yn_x_d = HALF_Q28 - 34'(p_i.xx) - 34'(p_i.yy);
    r_y_d  = 34'(p_i.xy) + 34'(p_i.wz);
    r_x_d  = HALF_Q28 - 34'(p_i.xx) - 34'(p_i.zz);
  end

  // stage three
  always_comb begin
    mag           = sp_q[15] ? 16'(-sp_q) : 16'(sp_q);
    side_d.lock   = mag > {1'b0, thr_i};
    side_d.sp     = sp_q;
    side_d.yaw_y  = side_d.lock ? yl_y_q : yn_y_q;
    side_d.yaw_x  = side_d.lock ? yl_x_q : yn_x_q;
    side_d.roll_y = r_y_q;
    side_d.roll_x = r_x_q;
    sq            = sp_q * sp_q;
    rad_d         = 29'(32'sd268435456 - sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q   <= sp_d;
      yl_y_q <= yl_y_d;
      yl_x_q <= yl_x_d;
      yn_y_q <= yn_y_d;
      yn_x_q <= yn_x_d;
      r_y_q  <= r_y_d;
      r_x_q  <= r_x_d;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

// File: rtl/qte_sqrt.sv
// pipelined floor square root of rad * 2^28, one root bit per stage
module qte_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [28:0]    rad_i,
  input  qte_pkg::side_t side_i,
  output logic           valid_o,
  output logic [28:0]    root_o,
  output qte_pkg::side_t side_o
);

  localparam int N = qte_pkg::SQ_STEPS;

  logic [31:0]    r_s [N];
  logic [28:0]    q_s [N];
  logic [57:0]    m_s [N];
  qte_pkg::side_t d_s [N];
  logic           v_s [N];

  logic [31:0]    r_d [N];
  logic [28:0]    q_d [N];
  logic [57:0]    m_d [N];

  logic [31:0]    r_q [N];
  logic [28:0]    q_q [N];
  logic [57:0]    m_q [N];
  qte_pkg::side_t d_q [N];
  logic           v_q [N];

  logic [31:0]    r_sh [N];
  logic [31:0]    t    [N];

  always_comb begin
    r_s[0] = '0;
    q_s[0] = '0;
    m_s[0] = {1'b0, rad_i, 28'd0};
    d_s[0] = side_i;
    v_s[0] = valid_i;
    for (int k = 1; k < N; k++) begin
      r_s[k] = r_q[k-1];
      q_s[k] = q_q[k-1];
      m_s[k] = m_q[k-1];
      d_s[k] = d_q[k-1];
      v_s[k] = v_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      r_sh[k] = {r_s[k][29:0], m_s[k][57:56]};
      t[k]    = {1'b0, q_s[k], 2'b01};
      m_d[k]  = {m_s[k][55:0], 2'b00};
      if (r_sh[k] >= t[k]) begin
        r_d[k] = r_sh[k] - t[k];
        q_d[k] = {q_s[k][27:0], 1'b1};
      end else begin
        r_d[k] = r_sh[k];
        q_d[k] = {q_s[k][27:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= v_s[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
        m_q[k] <= m_d[k];
        d_q[k] <= d_s[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = q_q[N-1];
  assign side_o  = d_q[N-1];

endmodule

// File: rtl/qte_cordic.sv
// unrolled vectoring cordic: atan2 of (x, y) as a 16-bit binary angle
module qte_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [qte_pkg::CW-1:0] x_i,
  input  logic signed [qte_pkg::CW-1:0] y_i,
  output logic                         valid_o,
  output logic [15:0]                  angle_o
);

  localparam int N  = qte_pkg::CORDIC_STAGES;
  localparam int CW = qte_pkg::CW;

  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic [31:0]          z_q [N+1];
  logic                 zr_q [N+1];
  logic                 v_q  [N+1];

  logic signed [CW-1:0] x_d [N+1];
  logic signed [CW-1:0] y_d [N+1];
  logic [31:0]          z_d [N+1];

  logic [31:0]          rnd;

  always_comb begin
    if (x_i < 0) begin
      x_d[0] = -x_i;
      y_d[0] = -y_i;
      z_d[0] = 32'h8000_0000;
    end else begin
      x_d[0] = x_i;
      y_d[0] = y_i;
      z_d[0] = '0;
    end
    for (int i = 0; i < N; i++) begin
      if (y_q[i] >= 0) begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + qte_pkg::ATAN_TAB[5'(i)];
      end else begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - qte_pkg::ATAN_TAB[5'(i)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i <= N; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q[0] <= (x_i == 0) && (y_i == 0);
      for (int i = 0; i <= N; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
      for (int i = 1; i <= N; i++) begin
        zr_q[i] <= zr_q[i-1];
      end
    end
  end

  assign rnd     = z_q[N] + 32'h0000_8000;
  assign valid_o = v_q[N];
  assign angle_o = zr_q[N] ? 16'd0 : rnd[31:16];

endmodule

// File: tb/quaternion_to_euler_angles_checker.sv
// checker: predicts euler angles from accepted quaternions and compares outputs
`timescale 1ns / 1ps
module quaternion_to_euler_angles_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [14:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  qte_pkg::quat_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  qte_pkg::euler_t out_data_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam logic signed [63:0] ONE_Q28  = 64'sd1 << 28;
  localparam logic signed [63:0] HALF_Q28 = 64'sd1 << 27;

  logic [14:0]     threshold;
  qte_pkg::euler_t angles_due[$];

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] binary_angle(logic signed [63:0] y,
                                                      logic signed [63:0] x);
    logic [31:0] acc;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [31:0] rounded;
    acc = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < qte_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + qte_pkg::ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - qte_pkg::ATAN_TAB[i];
      end
    end
    rounded = (acc + 32'h8000) >> 16;
    return rounded[15:0];
  endfunction

  function automatic qte_pkg::euler_t predict_angles(qte_pkg::quat_t q, logic [14:0] thr);
    logic signed [63:0] w, x, y, z, s28, sp, mag, pitch;
    logic [63:0] c2;
    qte_pkg::euler_t r;
    w = q.qw;
    x = q.qx;
    y = q.qy;
    z = q.qz;
    s28 = 2 * (w * x - y * z);
    if (s28 > ONE_Q28) s28 = ONE_Q28;
    if (s28 < -ONE_Q28) s28 = -ONE_Q28;
    sp = ((s28 + ONE_Q28 + 64'sd8192) >>> 14) - 64'sd16384;
    mag = sp < 0 ? -sp : sp;
    r.gimbal_lock = mag > $signed({49'd0, thr});
    if (r.gimbal_lock) begin
      pitch = sp;
      r.yaw_angle = binary_angle(w * y - x * z, HALF_Q28 - y * y - z * z);
      r.roll_angle = 16'sd0;
    end else begin
      c2 = (ONE_Q28 - sp * sp) << 28;
      pitch = binary_angle(sp * 16384, $signed(floor_sqrt(c2)));
      r.yaw_angle = binary_angle(x * z + w * y, HALF_Q28 - x * x - y * y);
      r.roll_angle = binary_angle(x * y + w * z, HALF_Q28 - x * x - z * z);
    end
    if (pitch > 16384) pitch = 16384;
    if (pitch < -16384) pitch = -16384;
    r.pitch_angle = pitch[15:0];
    return r;
  endfunction

  assign pending_o = angles_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    qte_pkg::euler_t e;
    if (!rst_ni) begin
      threshold <= 15'd16382;
      fail_count_o <= 0;
      angles_due.delete();
    end else begin
      if (cfg_we_i) threshold <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        angles_due.push_back(predict_angles(in_data_i, threshold));
      if (out_valid_i && out_ready_i) begin
        if (angles_due.size() == 0) begin
          $error("unexpected output word");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = angles_due.pop_front();
          if (out_data_i !== e) begin
            fail_count_o <= fail_count_o + 1;
            if (out_data_i.pitch_angle !== e.pitch_angle)
              $error("pitch_angle expected %0d actual %0d", e.pitch_angle,
                     out_data_i.pitch_angle);
            if (out_data_i.yaw_angle !== e.yaw_angle)
              $error("yaw_angle expected %0d actual %0d", e.yaw_angle,
                     out_data_i.yaw_angle);
            if (out_data_i.roll_angle !== e.roll_angle)
              $error("roll_angle expected %0d actual %0d", e.roll_angle,
                     out_data_i.roll_angle);
            if (out_data_i.gimbal_lock !== e.gimbal_lock)
              $error("gimbal_lock expected %0d actual %0d", e.gimbal_lock,
                     out_data_i.gimbal_lock);
          end
        end
      end
    end
  end
endmodule

// File: tb/quaternion_to_euler_angles_core_test.sv
// testbench top: drives quaternions and threshold phases, gives the verdict
`timescale 1ns / 1ps
module quaternion_to_euler_angles_core_test;

  localparam int PIPE_DEPTH = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [14:0]     cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  qte_pkg::quat_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  qte_pkg::euler_t out_data_o;
  int              fail_count;
  int              pending;
  int              cycle_count = 0;
  int              stall_mode = 0;

  always #10 clk_i = ~clk_i;

  quaternion_to_euler_angles_core uut (.*);

  quaternion_to_euler_angles_checker checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls: free-running, light, or heavy pattern by phase
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 2) == 0);
    endcase
  end

  task automatic send_burst(qte_pkg::quat_t q);
    // keep valid high within a burst: no lower and raise in one step
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      1: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
    endcase
  endfunction

  function automatic qte_pkg::quat_t rand_quat();
    qte_pkg::quat_t q;
    real a, b, c, d, n;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      a = $itor($signed(16'($urandom))); b = $itor($signed(16'($urandom)));
      c = $itor($signed(16'($urandom))); d = $itor($signed(16'($urandom)));
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      q.qw = 16'($rtoi(a / n * 16384.0)); q.qx = 16'($rtoi(b / n * 16384.0));
      q.qy = 16'($rtoi(c / n * 16384.0)); q.qz = 16'($rtoi(d / n * 16384.0));
    end else if (k < 8) begin
      // near gimbal lock: w and x about equal in magnitude, y and z small
      q.qw = 16'sd11585 + rand_comp(2);
      q.qx = ($urandom_range(0, 1) ? 16'sd11585 : -16'sd11585) + rand_comp(2);
      q.qy = rand_comp(2);
      q.qz = rand_comp(2);
      if ($urandom_range(0, 1)) q.qw = -q.qw;
    end else begin
      q.qw = rand_comp(k - 8); q.qx = rand_comp(k - 8);
      q.qy = rand_comp(k - 8); q.qz = rand_comp(k - 8);
    end
    return q;
  endfunction

  localparam logic [14:0] THRESHOLDS [6] = '{15'd0, 15'd16384, 15'd32767, 15'd16000,
                                             15'd8000, 15'd16382};

  initial begin
    qte_pkg::quat_t directed [$];
    int burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = {
      '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, '{16'sd11585, -16'sd11585, 16'sd0, 16'sd0},
      '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192},
      '{16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192},
      '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555},
      '{16'sd11580, 16'sd11590, 16'sd10, -16'sd10},
      '{-16'sd11585, 16'sd11585, 16'sd5, 16'sd5},
      '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585}
    };
    foreach (directed[i]) send_burst(directed[i]);
    drain_pipe();

    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(THRESHOLDS[ph]);
      stall_mode = ph % 3;
      for (int n = 0; n < 110; ) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst && n < 110; j++, n++) send_burst(rand_quat());
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        if (ph != 0 && n > 55 && n < 60 && burst > 0) begin
          // hold off until the pipeline has delivered everything
          while (pending != 0) @(posedge clk_i);
        end
        repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk_i);
      end
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
